// ===== rtl/hbs_pkg.sv =====
// shared types, constants and bit search functions for the hierarchical bitmap set
package hbs_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int KEY_W     = 12;
    localparam int CNT_W     = 13;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 13'd4096;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_ERASE  = 3'd1,
        FN_TEST   = 3'd2,
        FN_NEXT   = 3'd3,
        FN_PREV   = 3'd4,
        FN_MIN    = 3'd5,
        FN_MAX    = 3'd6
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LEAF,
        ST_DESCEND,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic start;
        logic leaf;
        logic descend;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic descend;
    } t_status;

    // lowest set bit, zero for an empty word
    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

    // highest set bit, zero for an empty word
    function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/hierarchical_bitmap_set_top.sv =====
// top level of the hierarchical bitmap set: sequencer plus datapath
//
// channel   direction  handshake                   payload
// in        in         i_in_valid / o_in_stall     i_func, i_key
// out       out        o_out_valid / i_out_stall   o_found, o_index, o_member_count,
//                                                  o_range_error
// cfg       in         i_cfg_we                    i_cfg_wdata (universe limit)
//
// an item reaches the output register through the start, leaf read and load states,
// with a descend state before the load when a search goes on to a second leaf word; the
// input opens again only once the result is loaded: one leaf access per level
// a held result stalls only the final load; the next item is accepted and worked on
// synchronous active-low reset empties the set and sets the limit to 4096; a limit
// write empties it too, with no clearing pass (per-word valid bits)
module hierarchical_bitmap_set_top #(
    parameter int CAPACITY = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_func,
    input  logic [hbs_pkg::KEY_W-1:0]   i_key,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [hbs_pkg::KEY_W-1:0]   o_index,
    output logic [hbs_pkg::CNT_W-1:0]   o_member_count,
    output logic                        o_range_error,
    // limit register write
    input  logic                        i_cfg_we,
    input  logic [hbs_pkg::CNT_W-1:0]   i_cfg_wdata
);

    hbs_pkg::t_cmd    cmd;
    hbs_pkg::t_status status;

    // sequencer: steps each item through its start, leaf, descend and output states
    hbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // leaf words, summary word, member count and the result registers
    hbs_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (status),
        .o_found        (o_found),
        .o_index        (o_index),
        .o_member_count (o_member_count),
        .o_range_error  (o_range_error)
    );

endmodule

// ===== rtl/hbs_ctrl.sv =====
// sequencer for the hierarchical bitmap set: steps one item through start, leaf, descend and out
module hbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  hbs_pkg::t_status i_status,
    output hbs_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);

    hbs_pkg::t_state r_state;
    hbs_pkg::t_state n_state;
    logic            r_out_valid;
    logic            can_load;

    // output register free, or being emptied this cycle
    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hbs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = hbs_pkg::ST_START;
                end
            end
            hbs_pkg::ST_START: begin
                n_state = hbs_pkg::ST_LEAF;
            end
            hbs_pkg::ST_LEAF: begin
                if (i_status.descend) begin
                    n_state = hbs_pkg::ST_DESCEND;
                end else begin
                    n_state = hbs_pkg::ST_OUT;
                end
            end
            hbs_pkg::ST_DESCEND: begin
                n_state = hbs_pkg::ST_OUT;
            end
            hbs_pkg::ST_OUT: begin
                if (can_load) begin
                    n_state = hbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == hbs_pkg::ST_IDLE) && i_in_valid;
        o_cmd.start    = (r_state == hbs_pkg::ST_START);
        o_cmd.leaf     = (r_state == hbs_pkg::ST_LEAF);
        o_cmd.descend  = (r_state == hbs_pkg::ST_DESCEND);
        o_cmd.out_load = (r_state == hbs_pkg::ST_OUT) && can_load;
    end

    assign o_in_stall  = (r_state != hbs_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hbs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/hbs_dpath.sv =====
// datapath of the hierarchical bitmap set: leaf memory, summary word, count and result registers
module hbs_dpath #(
    parameter int CAPACITY = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hbs_pkg::t_cmd               i_cmd,
    input  logic [2:0]                  i_func,
    input  logic [hbs_pkg::KEY_W-1:0]   i_key,
    input  logic                        i_cfg_we,
    input  logic [hbs_pkg::CNT_W-1:0]   i_cfg_wdata,
    output hbs_pkg::t_status            o_status,
    output logic                        o_found,
    output logic [hbs_pkg::KEY_W-1:0]   o_index,
    output logic [hbs_pkg::CNT_W-1:0]   o_member_count,
    output logic                        o_range_error
);

    localparam int WB    = hbs_pkg::WORD_BITS;
    localparam int BW    = hbs_pkg::BIT_W;
    localparam int KW    = hbs_pkg::KEY_W;
    localparam int CW    = hbs_pkg::CNT_W;
    localparam int DEPTH = (CAPACITY + hbs_pkg::WORD_BITS - 1) / hbs_pkg::WORD_BITS;
    localparam int WIDX  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] CAP_LIM = CW'(CAPACITY);

    // leaf store, one valid bit per word stands in for clearing
    logic [WB-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WB-1:0]    r_rd_data;
    logic             r_rd_vld;

    logic [CW-1:0]    r_limit;
    logic [WB-1:0]    r_summary;
    logic [CW-1:0]    r_members;

    hbs_pkg::t_func   r_func;
    logic [KW-1:0]    r_key;
    logic [KW-1:0]    r_start;
    logic             r_ok;
    logic             r_sum_hit;
    logic [BW-1:0]    r_sum_w;

    logic             r_found;
    logic [KW-1:0]    r_idx;
    logic             r_err;

    logic             r_o_found;
    logic [KW-1:0]    r_o_idx;
    logic [CW-1:0]    r_o_members;
    logic             r_o_err;

    // start step
    logic [CW-1:0]    lim;
    logic [CW-1:0]    lim_m1;
    logic [CW-1:0]    key13;
    logic [KW-1:0]    s_start;
    logic             s_ok;
    logic             s_up;
    logic [BW-1:0]    s_w;
    logic [WB-1:0]    s_sum_masked;
    logic             s_sum_hit;
    logic [BW-1:0]    s_sum_w;
    logic [WIDX-1:0]  rd_addr;
    logic             rd_en;

    // leaf and descend steps
    logic             up;
    logic [BW-1:0]    w;
    logic [BW-1:0]    b;
    logic [WB-1:0]    word;
    logic [WB-1:0]    bit_mask;
    logic             is_mem;
    logic [WB-1:0]    up_masked;
    logic [WB-1:0]    dn_masked;
    logic             l_found;
    logic [KW-1:0]    l_idx;
    logic             l_err;
    logic             l_wr;
    logic [WB-1:0]    l_wdata;
    logic             l_sum_set;
    logic             l_sum_clr;
    logic             l_inc;
    logic             l_dec;
    logic             l_descend;
    logic [KW-1:0]    d_idx;

    assign lim    = (r_limit > CAP_LIM) ? CAP_LIM : r_limit;
    assign lim_m1 = lim - CW'(1);
    assign key13  = {1'b0, r_key};

    always_comb begin
        s_start = '0;
        s_ok    = 1'b0;
        unique case (r_func)
            hbs_pkg::FN_INSERT, hbs_pkg::FN_ERASE, hbs_pkg::FN_TEST, hbs_pkg::FN_NEXT: begin
                s_start = r_key;
                s_ok    = (key13 < lim);
            end
            hbs_pkg::FN_PREV: begin
                // clamp a key at or beyond the limit down to the last valid key
                s_start = (key13 > lim_m1) ? lim_m1[KW-1:0] : r_key;
                s_ok    = (lim != '0);
            end
            hbs_pkg::FN_MIN: begin
                s_start = '0;
                s_ok    = (lim != '0);
            end
            hbs_pkg::FN_MAX: begin
                s_start = lim_m1[KW-1:0];
                s_ok    = (lim != '0);
            end
            default: begin
                s_start = '0;
                s_ok    = 1'b0;
            end
        endcase
    end

    assign up  = (r_func == hbs_pkg::FN_NEXT) || (r_func == hbs_pkg::FN_MIN);
    assign s_up = up;
    assign s_w = s_start[KW-1:BW];

    // summary words strictly above or below the start word
    assign s_sum_masked = s_up ? (r_summary & ((~{WB{1'b0}} << s_w) << 1))
                               : (r_summary & ~(~{WB{1'b0}} << s_w));
    assign s_sum_hit = |s_sum_masked;
    assign s_sum_w   = s_up ? hbs_pkg::low_bit(s_sum_masked) : hbs_pkg::high_bit(s_sum_masked);

    assign rd_en   = i_cmd.start || i_cmd.leaf;
    assign rd_addr = i_cmd.start ? (s_ok ? s_w[WIDX-1:0] : '0) : r_sum_w[WIDX-1:0];

    assign w         = r_start[KW-1:BW];
    assign b         = r_start[BW-1:0];
    assign word      = r_rd_vld ? r_rd_data : '0;
    assign bit_mask  = {{(WB-1){1'b0}}, 1'b1} << b;
    assign is_mem    = |(word & bit_mask);
    assign up_masked = word & (~{WB{1'b0}} << b);
    assign dn_masked = word & (~{WB{1'b0}} >> (BW'(WB - 1) - b));

    always_comb begin
        l_found   = 1'b0;
        l_idx     = '0;
        l_err     = 1'b0;
        l_wr      = 1'b0;
        l_wdata   = word;
        l_sum_set = 1'b0;
        l_sum_clr = 1'b0;
        l_inc     = 1'b0;
        l_dec     = 1'b0;
        l_descend = 1'b0;
        unique case (r_func)
            hbs_pkg::FN_INSERT: begin
                if (!r_ok) begin
                    l_err = 1'b1;
                end else if (!is_mem) begin
                    l_wr      = 1'b1;
                    l_wdata   = word | bit_mask;
                    l_sum_set = 1'b1;
                    l_inc     = 1'b1;
                end
            end
            hbs_pkg::FN_ERASE: begin
                if (!r_ok) begin
                    l_err = 1'b1;
                end else if (is_mem) begin
                    l_wr      = 1'b1;
                    l_wdata   = word & ~bit_mask;
                    l_sum_clr = ((word & ~bit_mask) == '0);
                    l_dec     = 1'b1;
                end
            end
            hbs_pkg::FN_TEST: begin
                if (!r_ok) begin
                    l_err = 1'b1;
                end else begin
                    l_found = is_mem;
                end
            end
            hbs_pkg::FN_NEXT, hbs_pkg::FN_MIN: begin
                if (r_ok) begin
                    if (|up_masked) begin
                        l_found = 1'b1;
                        l_idx   = {w, hbs_pkg::low_bit(up_masked)};
                    end else begin
                        l_descend = r_sum_hit;
                    end
                end
            end
            hbs_pkg::FN_PREV, hbs_pkg::FN_MAX: begin
                if (r_ok) begin
                    if (|dn_masked) begin
                        l_found = 1'b1;
                        l_idx   = {w, hbs_pkg::high_bit(dn_masked)};
                    end else begin
                        l_descend = r_sum_hit;
                    end
                end
            end
            default: begin
                l_found = 1'b0;
            end
        endcase
    end

    assign d_idx = {r_sum_w, up ? hbs_pkg::low_bit(word) : hbs_pkg::high_bit(word)};

    assign o_status.descend = l_descend;

    // leaf memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.leaf && l_wr) begin
            mem[w[WIDX-1:0]] <= l_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    // store control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= hbs_pkg::LIMIT_RESET;
            r_vld     <= '0;
            r_summary <= '0;
            r_members <= '0;
        end else if (i_cfg_we) begin
            r_limit   <= i_cfg_wdata;
            r_vld     <= '0;
            r_summary <= '0;
            r_members <= '0;
        end else if (i_cmd.leaf) begin
            if (l_wr) begin
                r_vld[w[WIDX-1:0]] <= 1'b1;
            end
            if (l_sum_set) begin
                r_summary[w] <= 1'b1;
            end else if (l_sum_clr) begin
                r_summary[w] <= 1'b0;
            end
            if (l_inc) begin
                r_members <= r_members + CW'(1);
            end else if (l_dec) begin
                r_members <= r_members - CW'(1);
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= hbs_pkg::t_func'(i_func);
            r_key  <= i_key;
        end
        if (i_cmd.start) begin
            r_start   <= s_start;
            r_ok      <= s_ok;
            r_sum_hit <= s_sum_hit;
            r_sum_w   <= s_sum_w;
        end
        if (i_cmd.leaf) begin
            r_found <= l_found;
            r_idx   <= l_idx;
            r_err   <= l_err;
        end else if (i_cmd.descend) begin
            r_found <= 1'b1;
            r_idx   <= d_idx;
        end
        if (i_cmd.out_load) begin
            r_o_found   <= r_found;
            r_o_idx     <= r_idx;
            r_o_members <= r_members;
            r_o_err     <= r_err;
        end
    end

    assign o_found        = r_o_found;
    assign o_index        = r_o_idx;
    assign o_member_count = r_o_members;
    assign o_range_error  = r_o_err;

endmodule
